/* src/chull_pkg.sv */
// ----------------------------------------------------------------------------
// Convex hull engine package
// Shared types, sizes and helpers for the monotone chain hull engine.
// ----------------------------------------------------------------------------
package chull_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int HULL_DEPTH = 2 * MAX_POINTS;
  localparam int HIDX_W     = $clog2(HULL_DEPTH);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int PT_W       = 2 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         set_end;
  } point_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         vertex_valid;
    logic                         final_vertex;
    logic                         overflowed;
  } hull_word_t;

  typedef struct packed {
    logic done;
    logic not_left;
  } cross_res_t;

  // Lexicographic order: by x, then by y.
  function automatic logic pt_less(pt_t a, pt_t b);
    logic r;
    if (a.x != b.x) begin
      r = (a.x < b.x);
    end else begin
      r = (a.y < b.y);
    end
    return r;
  endfunction

endpackage

/* src/chull_ram.sv */
// ----------------------------------------------------------------------------
// Convex hull engine RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module chull_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/chull_cross.sv */
// ----------------------------------------------------------------------------
// Convex hull engine turn test
// Cross product (a-p)x(b-p), registered as differences then each product, and its sign test against zero.
// ----------------------------------------------------------------------------
module chull_cross (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  chull_pkg::pt_t     a,
  input  chull_pkg::pt_t     b,
  input  chull_pkg::pt_t     p,
  output chull_pkg::cross_res_t res
);
  import chull_pkg::*;

  logic [2:0]                phase;
  logic signed [DIFF_W-1:0]  dax, day, dbx, dby;
  logic signed [PROD_W-1:0]  prod_a, prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= {phase[1:0], start};
    end
  end

  // Operands are held steady by the sequencer while the test runs.
  always_ff @(posedge clk) begin
    if (start) begin
      dax <= DIFF_W'(a.x) - DIFF_W'(p.x);
      day <= DIFF_W'(a.y) - DIFF_W'(p.y);
      dbx <= DIFF_W'(b.x) - DIFF_W'(p.x);
      dby <= DIFF_W'(b.y) - DIFF_W'(p.y);
    end
    if (phase[0]) begin
      prod_a <= dax * dby;
    end
    if (phase[1]) begin
      prod_b <= day * dbx;
    end
  end

  assign res.done     = phase[2];
  assign res.not_left = (prod_a <= prod_b);

endmodule

/* src/convex_hull_engine_core.sv */
// ----------------------------------------------------------------------------
// Convex hull engine core
// Monotone chain convex hull over a stored, insertion-sorted point set.
//
//   channel | valid       | stall       | word
//   --------+-------------+-------------+--------------------
//   input   | point_valid | point_stall | point (point_word_t)
//   output  | hull_valid  | hull_stall  | hull  (hull_word_t)
//
// Each point is insertion-sorted into the point RAM on arrival, one compare
// step per entry it moves past. After the last point, each chain pass
// fetches each point, runs turn tests against the top of the stack, pops
// and pushes; each hull word is read, loaded and held until taken (the
// empty-hull word is not read from the stack). Both memories are RAMs
// with one write port and one registered read port.
// Reset clears the point count, chain length and overflow flag; no memory
// clearing pass.
// ----------------------------------------------------------------------------
module convex_hull_engine_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    point_valid,
  output logic                    point_stall,
  input  chull_pkg::point_word_t  point,
  output logic                    hull_valid,
  input  logic                    hull_stall,
  output chull_pkg::hull_word_t   hull
);
  import chull_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INSCMP = 4'd1;
  localparam logic [3:0] S_INSPUT = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_WAIT   = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;
  localparam logic [3:0] S_OUTRD  = 4'd9;
  localparam logic [3:0] S_OUTLD  = 4'd10;
  localparam logic [3:0] S_HOLD   = 4'd11;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic [3:0]        state;
  pt_t               key, p, t1, t2;
  logic              endf, drop, upper;
  logic [CNT_W-1:0]  count, len, nl, total, len_push;
  logic [PIDX_W-1:0] idx, j, oi;
  logic [HIDX_W-1:0] base;
  logic [CNT_W:0]    sum;
  hull_word_t        out_q;

  logic              s_we, h_we, accept, out_take, cr_start;
  logic [PIDX_W-1:0] s_wa, s_ra;
  logic [HIDX_W-1:0] h_wa, h_ra;
  pt_t               s_wd, s_rd, h_wd, h_rd, in_pt;
  cross_res_t        cr;

  chull_ram #(.DEPTH(MAX_POINTS), .WIDTH(PT_W)) u_store (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  chull_ram #(.DEPTH(HULL_DEPTH), .WIDTH(PT_W)) u_stack (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  chull_cross u_cross (
    .clk(clk), .rst(rst), .start(cr_start), .a(t2), .b(t1), .p(p), .res(cr)
  );

  assign point_stall = (state != S_IDLE);
  assign accept      = point_valid && (state == S_IDLE);
  assign hull_valid  = (state == S_HOLD);
  assign hull        = out_q;
  assign out_take    = hull_valid && !hull_stall;
  assign cr_start    = (state == S_CHK);
  assign in_pt.x     = point.point_x;
  assign in_pt.y     = point.point_y;
  assign len_push    = (len < CNT_MAX) ? len + CNT_W'(1) : len;
  // Lower chain minus its last vertex plus upper chain minus its last.
  assign sum         = (CNT_W+1)'(nl) + (CNT_W+1)'(len_push) - (CNT_W+1)'(2);

  // Memory port control.
  always_comb begin
    s_we = 1'b0;
    s_wa = '0;
    s_wd = key;
    s_ra = '0;
    h_we = 1'b0;
    h_wa = base + HIDX_W'(len);
    h_wd = p;
    h_ra = '0;
    case (state)
      S_IDLE: begin
        if (accept && count == '0) begin
          s_we = 1'b1;
          s_wd = in_pt;
        end
        s_ra = PIDX_W'(count - CNT_W'(1));
      end
      S_INSCMP: begin
        s_we = 1'b1;
        s_wa = j;
        if (pt_less(key, s_rd)) begin
          s_wd = s_rd;
          s_ra = j - PIDX_W'(2);
        end
      end
      S_INSPUT: begin
        s_we = 1'b1;
        s_wa = j;
      end
      S_FETCH: s_ra = idx;
      S_WAIT:  h_ra = base + HIDX_W'(len) - HIDX_W'(3);
      S_PUSH:  h_we = (len < CNT_MAX);
      S_OUTRD: h_ra = HIDX_W'(oi);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      len   <= '0;
      drop  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key  <= in_pt;
            endf <= point.set_end;
            j    <= PIDX_W'(count);
            if (count == CNT_MAX) begin
              drop <= 1'b1;
            end else if (count == '0) begin
              count <= CNT_W'(1);
            end
            if (count != CNT_MAX && count != '0) begin
              state <= S_INSCMP;
            end else if (point.set_end) begin
              upper <= 1'b0;
              base  <= '0;
              len   <= '0;
              idx   <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_INSCMP: begin
          if (pt_less(key, s_rd)) begin
            j <= j - PIDX_W'(1);
            if (j == PIDX_W'(1)) begin
              state <= S_INSPUT;
            end
          end else begin
            count <= count + CNT_W'(1);
            upper <= 1'b0;
            base  <= '0;
            len   <= '0;
            idx   <= '0;
            state <= endf ? S_FETCH : S_IDLE;
          end
        end
        S_INSPUT: begin
          count <= count + CNT_W'(1);
          upper <= 1'b0;
          base  <= '0;
          len   <= '0;
          idx   <= '0;
          state <= endf ? S_FETCH : S_IDLE;
        end
        S_FETCH: state <= S_LOAD;
        S_LOAD: begin
          p     <= s_rd;
          state <= (len >= CNT_W'(2)) ? S_CHK : S_PUSH;
        end
        S_CHK: state <= S_WAIT;
        S_WAIT: begin
          if (cr.done) begin
            if (cr.not_left) begin
              len   <= len - CNT_W'(1);
              t1    <= t2;
              state <= S_POP;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_POP: begin
          // The vertex below the new top; unused when one vertex is left.
          t2    <= h_rd;
          state <= (len >= CNT_W'(2)) ? S_CHK : S_PUSH;
        end
        S_PUSH: begin
          if (len < CNT_MAX) begin
            t2 <= t1;
            t1 <= p;
          end
          if (!upper && CNT_W'(idx) == count - CNT_W'(1)) begin
            // The upper chain starts on top of the dropped last lower vertex.
            nl    <= len_push;
            base  <= HIDX_W'(len_push - CNT_W'(1));
            len   <= '0;
            upper <= 1'b1;
            idx   <= PIDX_W'(count - CNT_W'(1));
            state <= S_FETCH;
          end else begin
            len <= len_push;
            if (!upper) begin
              idx   <= idx + PIDX_W'(1);
              state <= S_FETCH;
            end else if (idx == '0) begin
              total <= (sum > (CNT_W+1)'(MAX_POINTS)) ? CNT_MAX : CNT_W'(sum);
              oi    <= '0;
              state <= S_OUTRD;
            end else begin
              idx   <= idx - PIDX_W'(1);
              state <= S_FETCH;
            end
          end
        end
        S_OUTRD: begin
          if (total == '0) begin
            out_q <= '{hull_x: '0, hull_y: '0, vertex_valid: 1'b0,
                       final_vertex: 1'b1, overflowed: drop};
            state <= S_HOLD;
          end else begin
            state <= S_OUTLD;
          end
        end
        S_OUTLD: begin
          out_q <= '{hull_x: h_rd.x, hull_y: h_rd.y, vertex_valid: 1'b1,
                     final_vertex: (CNT_W'(oi) == total - CNT_W'(1)),
                     overflowed: drop};
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_take) begin
            if (out_q.final_vertex) begin
              count <= '0;
              drop  <= 1'b0;
              state <= S_IDLE;
            end else begin
              oi    <= oi + PIDX_W'(1);
              state <= S_OUTRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("point count beyond capacity");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= CNT_MAX) else $error("chain length beyond capacity");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    out_take && hull.final_vertex |=> count == '0 && !drop)
    else $error("set state not cleared after last word");

  a_cross_done: assert property (@(posedge clk) disable iff (rst)
    cr.done |-> state == S_WAIT) else $error("turn test finished outside wait");

  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    hull_valid && !hull.vertex_valid |-> hull.final_vertex)
    else $error("empty hull word not marked final");

endmodule

/* dv/chull_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull checker
// Watches both channels of the hull engine, builds the expected hull of each
// point set with its own monotone chain and compares every hull word.
// ----------------------------------------------------------------------------
module chull_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  input  logic                   point_stall,
  input  chull_pkg::point_word_t point,
  input  logic                   hull_valid,
  input  logic                   hull_stall,
  input  chull_pkg::hull_word_t  hull,
  output int                     fail_count,
  output int                     pending,
  output int                     hulls_done,
  output int                     words_seen
);
  import chull_pkg::*;

  pt_t        set_pts[$];
  logic       set_dropped;
  hull_word_t hull_expect[$];

  function automatic logic lexi_less(pt_t a, pt_t b);
    if (a.x != b.x) return a.x < b.x;
    return a.y < b.y;
  endfunction

  // True when the turn a -> b -> p is clockwise or straight.
  function automatic logic turns_right(pt_t a, pt_t b, pt_t p);
    longint ax, ay, bx, by;
    ax = longint'(a.x) - longint'(p.x);
    ay = longint'(a.y) - longint'(p.y);
    bx = longint'(b.x) - longint'(p.x);
    by = longint'(b.y) - longint'(p.y);
    return (ax * by - ay * bx) <= 0;
  endfunction

  task automatic build_hull();
    pt_t        srt[$];
    pt_t        lo[MAX_POINTS];
    pt_t        up[MAX_POINTS];
    pt_t        key;
    hull_word_t w;
    int         j, total, nlo, nup;
    srt = set_pts;
    nlo = 0;
    nup = 0;
    for (int i = 1; i < srt.size(); i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && lexi_less(key, srt[j-1])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    foreach (srt[i]) begin
      while (nlo >= 2 && turns_right(lo[nlo-2], lo[nlo-1], srt[i]))
        nlo--;
      if (nlo < MAX_POINTS) begin
        lo[nlo] = srt[i];
        nlo++;
      end
    end
    for (int i = srt.size() - 1; i >= 0; i--) begin
      while (nup >= 2 && turns_right(up[nup-2], up[nup-1], srt[i]))
        nup--;
      if (nup < MAX_POINTS) begin
        up[nup] = srt[i];
        nup++;
      end
    end
    if (nlo > 0) nlo--;
    if (nup > 0) nup--;
    total = nlo + nup;
    if (total > MAX_POINTS) total = MAX_POINTS;
    if (total == 0) begin
      w = '0;
      w.final_vertex = 1'b1;
      w.overflowed = set_dropped;
      hull_expect = {hull_expect, w};
    end else begin
      for (int i = 0; i < total; i++) begin
        key = (i < nlo) ? lo[i] : up[i - nlo];
        w.hull_x = key.x;
        w.hull_y = key.y;
        w.vertex_valid = 1'b1;
        w.final_vertex = (i == total - 1);
        w.overflowed = set_dropped;
        hull_expect = {hull_expect, w};
      end
    end
  endtask

  always @(posedge clk) begin
    hull_word_t e;
    pt_t        p;
    if (rst) begin
      set_pts.delete();
      set_dropped = 1'b0;
      hull_expect.delete();
      fail_count <= 0;
      hulls_done <= 0;
      words_seen <= 0;
      pending    <= 0;
    end else begin
      if (point_valid && !point_stall) begin
        p.x = point.point_x;
        p.y = point.point_y;
        if (set_pts.size() < MAX_POINTS) set_pts = {set_pts, p};
        else set_dropped = 1'b1;
        if (point.set_end) begin
          build_hull();
          set_pts.delete();
          set_dropped = 1'b0;
        end
      end
      if (hull_valid && !hull_stall) begin
        words_seen <= words_seen + 1;
        if (hull_expect.size() == 0) begin
          $error("hull word with nothing expected: %p", hull);
          fail_count <= fail_count + 1;
        end else begin
          e = hull_expect.pop_front();
          if (hull.final_vertex) hulls_done <= hulls_done + 1;
          if (hull !== e) begin
            fail_count <= fail_count + 1;
            if (hull.hull_x !== e.hull_x)
              $error("hull_x expected %0d got %0d", e.hull_x, hull.hull_x);
            if (hull.hull_y !== e.hull_y)
              $error("hull_y expected %0d got %0d", e.hull_y, hull.hull_y);
            if (hull.vertex_valid !== e.vertex_valid)
              $error("vertex_valid expected %0b got %0b",
                     e.vertex_valid, hull.vertex_valid);
            if (hull.final_vertex !== e.final_vertex)
              $error("final_vertex expected %0b got %0b",
                     e.final_vertex, hull.final_vertex);
            if (hull.overflowed !== e.overflowed)
              $error("overflowed expected %0b got %0b",
                     e.overflowed, hull.overflowed);
          end
        end
      end
      pending <= hull_expect.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull engine testbench
// Sends directed and random point sets with random gaps and output stalls;
// the checker predicts every hull word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import chull_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        point_valid = 1'b0;
  logic        point_stall;
  point_word_t point = '0;
  logic        hull_valid;
  logic        hull_stall = 1'b0;
  hull_word_t  hull;
  int          fail_count, pending, hulls_done, words_seen;
  int          cycles = 0;
  int          words_sent = 0;
  bit          hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  convex_hull_engine_core DUT (
    .clk, .rst, .point_valid, .point_stall, .point, .hull_valid, .hull_stall, .hull
  );

  chull_checker u_checker (
    .clk, .rst, .point_valid, .point_stall, .point, .hull_valid, .hull_stall, .hull,
    .fail_count, .pending, .hulls_done, .words_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[convex_hull_engine_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stall pattern, quiet stretches, and one long hold-off.
  initial begin
    int mode;
    @(posedge clk iff !rst);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        if (hold_off) begin
          hull_stall <= 1'b1;
          repeat (4000) @(posedge clk);
          hold_off = 1'b0;
        end
        hull_stall <= (mode == 0) ? 1'b0 : (mode == 1) ? ($urandom_range(0, 3) == 0)
                                                       : ($urandom_range(0, 1) == 1);
        @(posedge clk);
      end
    end
  end

  task automatic send_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                            logic last);
    point_word_t w;
    w.point_x = x;
    w.point_y = y;
    w.set_end = last;
    point <= w;
    point_valid <= 1'b1;
    @(posedge clk iff !point_stall);
    words_sent++;
    if ($urandom_range(0, 3) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    point_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int spread);
    case ($urandom_range(0, 3))
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return COORD_BITS'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic send_random_set(int n, int spread);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(spread), rand_coord(spread), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single point gives an empty hull.
    send_point(16'sh7FFF, 16'sh8000, 1'b1);
    // Two distinct points, then all points equal.
    send_point(16'sh0005, -16'sd3, 1'b0);
    send_point(-16'sd7, 16'sh0002, 1'b1);
    send_point(16'sd9, 16'sd9, 1'b0);
    send_point(16'sd9, 16'sd9, 1'b0);
    send_point(16'sd9, 16'sd9, 1'b1);
    // Extreme corners with collinear edge points and an interior point.
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh0000, 16'sh8000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(-16'sd1, 16'sh7FFF, 1'b1);
    // Collinear set only.
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b1);

    // Pause the sender until every hull word is back.
    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    // Overflow: more points than the store holds, ending with a dropped point.
    // The receiver then holds off while the next set is offered and stalled.
    send_random_set(MAX_POINTS + 3, 1000);
    hold_off = 1'b1;

    while (words_sent < 130) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      send_random_set(n, $urandom_range(0, 1) ? 20 : 30000);
      if ($urandom_range(0, 2) == 0) begin
        point_valid <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end
    end
    drop_valid();

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d points; checked %0d hull words over %0d hulls, incl. overflow.",
             words_sent, words_seen, hulls_done);
    if (fail_count == 0) begin
      $display("[convex_hull_engine_core] OK");
    end else begin
      $display("[convex_hull_engine_core] ERROR");
    end
    $finish;
  end

endmodule
